FILE: design/gdc_pkg.sv
// ----------------------------------------------------------------------------
// Gesture direction classifier package
// Shared widths, channel order, result codes and lane control types.
// ----------------------------------------------------------------------------
package gdc_pkg;

   // Field widths
   localparam int SAMPLE_W = 8;
   localparam int MIN_W    = 6;
   localparam int DIR_W    = 3;
   localparam int ERR_W    = 2;

   // Frame geometry
   localparam int MAX_SAMPLES_DEF = 32;
   localparam int NUM_LANES       = 4;
   localparam int CENTRE_SCALE    = 100;

   localparam logic [MIN_W-1:0] MIN_SAMPLES_RST = 6'd4;

   // Channel order across the lanes
   localparam int CH_UP    = 0;
   localparam int CH_DOWN  = 1;
   localparam int CH_LEFT  = 2;
   localparam int CH_RIGHT = 3;

   // Direction codes
   localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
   localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_ZERO_SUM = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

   // Controls sent from the sequencer to every lane
   typedef struct packed {
      logic acc_en;  // add this request's sample
      logic load;    // start the divider from the sums, clear the sums
      logic step;    // one quotient bit
   } lane_ctrl_type;

   // Result of the merging stage
   typedef struct packed {
      logic [DIR_W-1:0] direction;
      logic             zero_seen;
   } merge_res_type;

endpackage

FILE: design/gdc_channels_if.sv
// ----------------------------------------------------------------------------
// Gesture direction classifier channels
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gdc_req_if
   import gdc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] up_sample;
   logic [SAMPLE_W-1:0] down_sample;
   logic [SAMPLE_W-1:0] left_sample;
   logic [SAMPLE_W-1:0] right_sample;
   logic                last_sample;

   modport source (output valid, up_sample, down_sample, left_sample, right_sample,
                   last_sample, input ready);
   modport sink   (input valid, up_sample, down_sample, left_sample, right_sample,
                   last_sample, output ready);
endinterface

interface gdc_rsp_if
   import gdc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [DIR_W-1:0] direction;
   logic [ERR_W-1:0] error;

   modport source (output valid, direction, error, input ready);
   modport sink   (input valid, direction, error, output ready);
endinterface

interface gdc_csr_if
   import gdc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [MIN_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

FILE: design/gdc_lane.sv
// ----------------------------------------------------------------------------
// Gesture direction classifier lane
// Accumulates one channel's sum and position-weighted sum, then finds its
// centre of mass with a restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module gdc_lane
   import gdc_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  lane_ctrl_type                               ctrl,
   input  logic [$clog2(MAX_SAMPLES+1)-1:0]            pos,
   input  logic [SAMPLE_W-1:0]                         sample,
   output logic [$clog2(MAX_SAMPLES*CENTRE_SCALE+1)-1:0] centre,
   output logic                                        zero_sum
);

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W  = $clog2(255 * MAX_SAMPLES + 1);
   localparam int WSUM_W = $clog2(255 * MAX_SAMPLES * (MAX_SAMPLES + 1) / 2 + 1);
   localparam int DVD_W  = WSUM_W + 7;
   localparam int Q_W    = $clog2(MAX_SAMPLES * CENTRE_SCALE + 1);

   logic [SUM_W-1:0]  sum_ff,  sum_in;
   logic [WSUM_W-1:0] wsum_ff, wsum_in;
   logic [SUM_W-1:0]  dsr_ff,  dsr_in;
   logic [SUM_W-1:0]  rem_ff,  rem_in;
   logic [Q_W-1:0]    quo_ff,  quo_in;
   logic              zero_ff, zero_in;

   logic [SAMPLE_W+CNT_W-1:0] product;
   logic [DVD_W-1:0]          dividend;
   logic [DVD_W-1:0]          rem_start;
   logic [SUM_W:0]            trial;
   logic [SUM_W:0]            trial_diff;
   logic                      fits;

   // Weight the sample by its position and scale the weighted sum
   assign product   = (SAMPLE_W+CNT_W)'(sample) * (SAMPLE_W+CNT_W)'(pos);
   assign dividend  = DVD_W'(wsum_ff) * DVD_W'(CENTRE_SCALE);
   assign rem_start = dividend >> Q_W;

   // One restoring step: bring down the next dividend bit and try the divisor
   assign trial      = {rem_ff, quo_ff[Q_W-1]};
   assign trial_diff = trial - {1'b0, dsr_ff};
   assign fits       = (trial >= {1'b0, dsr_ff});

   always_comb begin
      sum_in  = sum_ff;
      wsum_in = wsum_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      zero_in = zero_ff;
      if (ctrl.acc_en) begin
         sum_in  = sum_ff + SUM_W'(sample);
         wsum_in = wsum_ff + WSUM_W'(product);
      end
      if (ctrl.load) begin
         // quotient is known to fit Q_W bits, so the upper part starts the remainder
         dsr_in  = sum_ff;
         zero_in = (sum_ff == '0);
         rem_in  = rem_start[SUM_W-1:0];
         quo_in  = dividend[Q_W-1:0];
         sum_in  = '0;
         wsum_in = '0;
      end else if (ctrl.step) begin
         rem_in = fits ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
         quo_in = {quo_ff[Q_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         wsum_ff <= '0;
      end else begin
         sum_ff  <= sum_in;
         wsum_ff <= wsum_in;
      end
      dsr_ff  <= dsr_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      zero_ff <= zero_in;
   end

   // A channel with no light has its centre forced to zero
   assign centre   = zero_ff ? '0 : quo_ff;
   assign zero_sum = zero_ff;

endmodule

FILE: design/gdc_merge.sv
// ----------------------------------------------------------------------------
// Gesture direction classifier merge
// Compares the horizontal and vertical centre differences of the four lanes
// and picks the direction; ties go to vertical.
// ----------------------------------------------------------------------------
module gdc_merge
   import gdc_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic [NUM_LANES-1:0][$clog2(MAX_SAMPLES*CENTRE_SCALE+1)-1:0] centre,
   input  logic [NUM_LANES-1:0]                                        zero_sum,
   output merge_res_type                                               result
);

   localparam int Q_W = $clog2(MAX_SAMPLES * CENTRE_SCALE + 1);

   logic signed [Q_W:0] horiz;
   logic signed [Q_W:0] vert;
   logic [Q_W:0]        horiz_neg;
   logic [Q_W:0]        vert_neg;
   logic [Q_W-1:0]      horiz_mag;
   logic [Q_W-1:0]      vert_mag;

   // Signed differences of the centres
   assign horiz = signed'({1'b0, centre[CH_RIGHT]}) - signed'({1'b0, centre[CH_LEFT]});
   assign vert  = signed'({1'b0, centre[CH_UP]})    - signed'({1'b0, centre[CH_DOWN]});

   assign horiz_neg = -horiz;
   assign vert_neg  = -vert;
   assign horiz_mag = horiz[Q_W] ? horiz_neg[Q_W-1:0] : horiz[Q_W-1:0];
   assign vert_mag  = vert[Q_W]  ? vert_neg[Q_W-1:0]  : vert[Q_W-1:0];

   // Larger magnitude wins; the sign picks the direction
   always_comb begin
      if (horiz_mag > vert_mag) begin
         result.direction = horiz[Q_W] ? DIR_RIGHT : DIR_LEFT;
      end else begin
         result.direction = vert[Q_W] ? DIR_UP : DIR_DOWN;
      end
      result.zero_seen = |zero_sum;
   end

endmodule

FILE: design/gesture_direction_classifier_core.sv
// Response: registered and raised from the done state; after the frame's last
//   request the block passes through the load, divide and done states.
// Throughput: one sample request a cycle within a frame; after a frame end
//   requests wait for the bit-serial lane dividers and the response write.
// Reset: synchronous, active high; clears the accumulators, the sample count,
//   the overflow flag and response valid, and sets min_samples to 4.
// ----------------------------------------------------------------------------
// Gesture direction classifier core
// Four channel lanes accumulate and divide side by side; a merging stage
// classifies the frame and a response register holds the result.
// ----------------------------------------------------------------------------
module gesture_direction_classifier_core
   import gdc_pkg::*;
#(
   parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
   input  logic clock,
   input  logic reset,
   gdc_req_if.sink   req_chan,
   gdc_rsp_if.source rsp_chan,
   gdc_csr_if.sink   csr_chan
);

   localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
   localparam int Q_W    = $clog2(MAX_SAMPLES * CENTRE_SCALE + 1);
   localparam int STEP_W = $clog2(Q_W + 1);
   localparam int CMP_W  = (CNT_W > MIN_W) ? CNT_W : MIN_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in;
   logic [MIN_W-1:0]   min_ff, min_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               enough_ff, enough_in;
   logic               frame_ovf_ff, frame_ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIR_W-1:0]   rsp_dir_ff, rsp_dir_in;
   logic [ERR_W-1:0]   rsp_err_ff, rsp_err_in;

   lane_ctrl_type                     lane_ctrl;
   logic [NUM_LANES-1:0][SAMPLE_W-1:0] samples;
   logic [NUM_LANES-1:0][Q_W-1:0]     centres;
   logic [NUM_LANES-1:0]              zeros;
   merge_res_type                     merged;
   logic                              req_fire;
   logic                              write_rsp;
   logic                              has_room;

   // Route the request's channels to the lanes
   assign samples[CH_UP]    = req_chan.up_sample;
   assign samples[CH_DOWN]  = req_chan.down_sample;
   assign samples[CH_LEFT]  = req_chan.left_sample;
   assign samples[CH_RIGHT] = req_chan.right_sample;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign has_room       = (cnt_ff < CNT_W'(MAX_SAMPLES));
   assign write_rsp      = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   assign csr_chan.ready = 1'b1;

   // Lanes, one per photodiode channel
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      gdc_lane #(
         .MAX_SAMPLES (MAX_SAMPLES)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (lane_ctrl),
         .pos      (cnt_in),
         .sample   (samples[g]),
         .centre   (centres[g]),
         .zero_sum (zeros[g])
      );
   end

   gdc_merge #(
      .MAX_SAMPLES (MAX_SAMPLES)
   ) u_merge (
      .centre   (centres),
      .zero_sum (zeros),
      .result   (merged)
   );

   // Sequence the frame: accumulate, load dividers, divide, respond
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      min_in       = min_ff;
      step_in      = step_ff;
      enough_in    = enough_ff;
      frame_ovf_in = frame_ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_err_in   = rsp_err_ff;
      lane_ctrl    = '0;

      if (csr_chan.valid) begin
         min_in = csr_chan.data;
      end

      // drop the response once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (has_room) begin
                  lane_ctrl.acc_en = 1'b1;
                  cnt_in           = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_chan.last_sample) begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            lane_ctrl.load = 1'b1;
            enough_in      = (CMP_W'(cnt_ff) >= CMP_W'(min_ff));
            frame_ovf_in   = ovf_ff;
            cnt_in         = '0;
            ovf_in         = 1'b0;
            step_in        = STEP_W'(Q_W);
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            lane_ctrl.step = 1'b1;
            step_in        = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (write_rsp) begin
               rsp_valid_in = 1'b1;
               rsp_dir_in   = enough_ff ? merged.direction : DIR_NONE;
               if (frame_ovf_ff) begin
                  rsp_err_in = ERR_OVERFLOW;
               end else if (enough_ff && merged.zero_seen) begin
                  rsp_err_in = ERR_ZERO_SUM;
               end else begin
                  rsp_err_in = ERR_OK;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         min_ff       <= MIN_SAMPLES_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff      <= step_in;
      enough_ff    <= enough_in;
      frame_ovf_ff <= frame_ovf_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.direction = rsp_dir_ff;
   assign rsp_chan.error     = rsp_err_ff;

   // Checks on the sequencer
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count beyond frame limit");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

   a_short_frame_none: assert property (@(posedge clock) disable iff (reset)
      write_rsp && !enough_ff |=> rsp_dir_ff == DIR_NONE)
      else $error("short frame classified");

   a_div_to_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && (step_ff == STEP_W'(1)) |=> state_ff == ST_DONE)
      else $error("divider sequence did not finish");

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> cnt_ff == '0 && !ovf_ff)
      else $error("frame state not cleared after load");

endmodule
